// File: src/sound_channel_mapper_defines.svh
// Assertion macros for the sound channel mapper.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef SOUND_CHANNEL_MAPPER_DEFINES_SVH
`define SOUND_CHANNEL_MAPPER_DEFINES_SVH
`ifndef SYNTH
`define SCM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("scm assertion failed");
`define SCM_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("scm assertion failed");
`else
`define SCM_ASSERT(lbl, clk, rst, prop)
`define SCM_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: src/scm_pkg.sv
// Package for the sound channel mapper: sizes, operation codes and the
// structs passed between the sequencer and the sound map store. No dependencies.
package scm_pkg;

   localparam int NUM_CHANNELS = 8;
   localparam int NUM_SOUNDS   = 128;

   localparam int CH_W    = 3;
   localparam int SND_W   = 7;
   localparam int FUNC_W  = 3;
   localparam int CNT_W   = $clog2(NUM_SOUNDS + 1);
   localparam int REQ_W   = 24;
   localparam int RSP_W   = 16;
   localparam int RES_W   = 2 + CH_W + SND_W;

   localparam logic [FUNC_W-1:0] FUNC_GRAB      = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOOK_SND  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_LOOK_CHN  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_CLR_SND   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_CLR_CHN   = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_CLR_ALL   = 3'd5;

   typedef struct packed {
      logic [SND_W-1:0] rd_addr;
      logic             wr_en;
      logic [SND_W-1:0] wr_addr;
      logic             wr_valid;
      logic [CH_W-1:0]  wr_chan;
      logic             clr_all;
   } s2c_cmd_type;

   typedef struct packed {
      logic            valid;
      logic [CH_W-1:0] chan;
   } s2c_rd_type;

   typedef struct packed {
      logic             sound_found;
      logic [SND_W-1:0] out_sound;
      logic             channel_found;
      logic [CH_W-1:0]  out_channel;
   } result_type;

endpackage

// File: src/scm_sound_map.sv
// Sound-to-channel map store: channel memory plus per-entry valid flops.
// Depends on scm_pkg.
module scm_sound_map (
   input  logic                 clock,
   input  logic                 reset,
   input  scm_pkg::s2c_cmd_type cmd,
   output scm_pkg::s2c_rd_type  rd
);
   import scm_pkg::*;

   logic [CH_W-1:0]       s2c_mem [NUM_SOUNDS];
   logic [NUM_SOUNDS-1:0] vld_ff, vld_in;
   logic [CH_W-1:0]       rd_chan_ff;
   logic                  rd_vld_ff;

   always_comb begin
      vld_in = vld_ff;
      if (cmd.wr_en) begin
         vld_in[cmd.wr_addr] = cmd.wr_valid;
      end
      if (cmd.clr_all) begin
         vld_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         rd_vld_ff <= vld_ff[cmd.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en && cmd.wr_valid) begin
         s2c_mem[cmd.wr_addr] <= cmd.wr_chan;
      end
      rd_chan_ff <= s2c_mem[cmd.rd_addr];
   end

   assign rd.valid = rd_vld_ff;
   assign rd.chan  = rd_chan_ff;

endmodule

// File: src/sound_channel_mapper.sv
// Sound channel mapper top level: operation sequencer, channel map, free mask.
// Depends on scm_pkg, scm_sound_map and sound_channel_mapper_defines.svh.
//
//  group  dir  fields (lsb first)                                   beats
//  req    in   tuser: func; tdata: sound, channel, playing_mask      one per op
//  rsp    out  tdata: out_channel, channel_found, out_sound,         one per op
//              sound_found
//
// Grab, lookup sound and clear sound go through one sound map read and one
// decision before the output register. Lookup/clear channel finish on a
// direct reverse map hit; on a miss the sound map is scanned one entry per
// cycle through its single read port. Clear all goes straight to output.
// Reset is synchronous; no clearing pass. A stalled rsp holds the next
// result in the sequencer; a new req is taken while a result waits in rsp.
`include "sound_channel_mapper_defines.svh"
module sound_channel_mapper (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [scm_pkg::REQ_W-1:0]  req_tdata,  // sound, channel, playing_mask
   input  logic [scm_pkg::FUNC_W-1:0] req_tuser,  // func
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [scm_pkg::RSP_W-1:0]  rsp_tdata   // out_channel, channel_found,
                                                  // out_sound, sound_found
);
   import scm_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SND  = 3'd1;
   localparam logic [2:0] ST_CHN  = 3'd2;
   localparam logic [2:0] ST_SCAN = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [FUNC_W-1:0]       func_ff, func_in;
   logic [SND_W-1:0]        snd_ff, snd_in;
   logic [CH_W-1:0]         chn_ff, chn_in;
   logic [NUM_CHANNELS-1:0] play_ff, play_in;
   logic [NUM_CHANNELS-1:0] c2s_vld_ff, c2s_vld_in;
   logic [SND_W-1:0]        c2s_snd_ff [NUM_CHANNELS];
   logic [SND_W-1:0]        c2s_snd_in [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] free_ff, free_in;
   logic [CH_W-1:0]         last_ff, last_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    pend_ff, pend_in;
   logic [SND_W-1:0]        pidx_ff, pidx_in;
   result_type              res_ff, res_in;
   logic                    rsp_vld_ff, rsp_vld_in;
   result_type              rsp_data_ff, rsp_data_in;

   s2c_cmd_type cmd;
   s2c_rd_type  rd;

   logic [SND_W-1:0]  req_snd;
   logic [CH_W-1:0]   req_chn;
   logic [NUM_CHANNELS-1:0] req_play;
   logic              accept;
   logic              snd_ok, chn_ok;
   logic              c_hit;
   logic [CH_W-1:0]   c_idx;
   logic              fc_found;
   logic [CH_W-1:0]   fc_chan;
   logic              a1_hit, a2_hit;
   logic [CH_W-1:0]   a1_idx, a2_idx, wrap_idx, alloc_idx, grant;
   logic              chn_done, chn_hit;
   logic [SND_W-1:0]  chn_snd;

   assign req_snd  = req_tdata[SND_W-1:0];
   assign req_chn  = req_tdata[SND_W+CH_W-1:SND_W];
   assign req_play = req_tdata[SND_W+CH_W+NUM_CHANNELS-1:SND_W+CH_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign snd_ok = {1'b0, snd_ff} < (SND_W+1)'(NUM_SOUNDS);
   assign chn_ok = {1'b0, chn_ff} < (CH_W+1)'(NUM_CHANNELS);

   // reverse map search and channel allocation, lowest index wins
   always_comb begin
      c_hit  = 1'b0;
      c_idx  = '0;
      a1_hit = 1'b0;
      a1_idx = '0;
      a2_hit = 1'b0;
      a2_idx = '0;
      for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
         if (c2s_vld_ff[i] && (c2s_snd_ff[i] == snd_ff)) begin
            c_hit = 1'b1;
            c_idx = CH_W'(i);
         end
         if (free_ff[i] && !play_ff[i]) begin
            a1_hit = 1'b1;
            a1_idx = CH_W'(i);
         end
         if (!play_ff[i]) begin
            a2_hit = 1'b1;
            a2_idx = CH_W'(i);
         end
      end
   end

   assign fc_found  = snd_ok && (rd.valid || c_hit);
   assign fc_chan   = rd.valid ? rd.chan : c_idx;
   assign wrap_idx  = (last_ff == CH_W'(NUM_CHANNELS - 1)) ? '0 : last_ff + 1'b1;
   assign alloc_idx = a1_hit ? a1_idx : (a2_hit ? a2_idx : wrap_idx);
   assign grant     = fc_found ? fc_chan : alloc_idx;

   always_comb begin
      state_in    = state_ff;
      func_in     = func_ff;
      snd_in      = snd_ff;
      chn_in      = chn_ff;
      play_in     = play_ff;
      c2s_vld_in  = c2s_vld_ff;
      c2s_snd_in  = c2s_snd_ff;
      free_in     = free_ff;
      last_in     = last_ff;
      cnt_in      = cnt_ff;
      pend_in     = 1'b0;
      pidx_in     = pidx_ff;
      res_in      = res_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      chn_done    = 1'b0;
      chn_hit     = 1'b0;
      chn_snd     = c2s_snd_ff[chn_ff];
      cmd         = '0;
      cmd.rd_addr = req_snd;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               func_in = req_tuser;
               snd_in  = req_snd;
               chn_in  = req_chn;
               play_in = req_play;
               res_in  = '0;
               unique case (req_tuser) inside
                  FUNC_GRAB, FUNC_LOOK_SND, FUNC_CLR_SND: state_in = ST_SND;
                  FUNC_LOOK_CHN, FUNC_CLR_CHN:             state_in = ST_CHN;
                  FUNC_CLR_ALL: begin
                     cmd.clr_all = 1'b1;
                     c2s_vld_in  = '0;
                     free_in     = '1;
                     last_in     = '0;
                     state_in    = ST_OUT;
                  end
                  default: state_in = ST_OUT;
               endcase
            end
         end
         ST_SND: begin
            unique case (func_ff)
               FUNC_GRAB: begin
                  if (snd_ok) begin
                     if (!fc_found) begin
                        last_in = alloc_idx;
                     end
                     free_in[grant]    = 1'b0;
                     c2s_vld_in[grant] = 1'b1;
                     c2s_snd_in[grant] = snd_ff;
                     cmd.wr_en         = 1'b1;
                     cmd.wr_addr       = snd_ff;
                     cmd.wr_valid      = 1'b1;
                     cmd.wr_chan       = grant;
                     res_in.out_channel   = grant;
                     res_in.channel_found = 1'b1;
                  end
               end
               FUNC_LOOK_SND: begin
                  if (fc_found) begin
                     res_in.out_channel   = fc_chan;
                     res_in.channel_found = 1'b1;
                  end
               end
               FUNC_CLR_SND: begin
                  if (snd_ok) begin
                     cmd.wr_en   = 1'b1;
                     cmd.wr_addr = snd_ff;
                     if (fc_found) begin
                        c2s_vld_in[fc_chan] = 1'b0;
                        free_in[fc_chan]    = 1'b1;
                     end
                  end
               end
               default: ;
            endcase
            state_in = ST_OUT;
         end
         ST_CHN: begin
            cnt_in = '0;
            if (!chn_ok) begin
               state_in = ST_OUT;
            end else if (c2s_vld_ff[chn_ff]) begin
               chn_done = 1'b1;
               chn_hit  = 1'b1;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.rd_addr = cnt_ff[SND_W-1:0];
            if (cnt_ff < CNT_W'(NUM_SOUNDS)) begin
               pend_in = 1'b1;
               pidx_in = cnt_ff[SND_W-1:0];
               cnt_in  = cnt_ff + 1'b1;
            end
            chn_snd = pidx_ff;
            if (pend_ff && rd.valid && (rd.chan == chn_ff)) begin
               chn_done = 1'b1;
               chn_hit  = 1'b1;
            end else if (!pend_ff && (cnt_ff == CNT_W'(NUM_SOUNDS))) begin
               chn_done = 1'b1;
            end
         end
         ST_OUT: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = res_ff;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (chn_done) begin
         pend_in  = 1'b0;
         state_in = ST_OUT;
         if ((func_ff == FUNC_LOOK_CHN) && chn_hit) begin
            res_in.out_sound   = chn_snd;
            res_in.sound_found = 1'b1;
         end
         if (func_ff == FUNC_CLR_CHN) begin
            c2s_vld_in[chn_ff] = 1'b0;
            free_in[chn_ff]    = 1'b1;
            if (chn_hit) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_addr = chn_snd;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         c2s_vld_ff <= '0;
         free_ff    <= '1;
         last_ff    <= '0;
         pend_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         c2s_vld_ff <= c2s_vld_in;
         free_ff    <= free_in;
         last_ff    <= last_in;
         pend_ff    <= pend_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      snd_ff      <= snd_in;
      chn_ff      <= chn_in;
      play_ff     <= play_in;
      c2s_snd_ff  <= c2s_snd_in;
      cnt_ff      <= cnt_in;
      pidx_ff     <= pidx_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   scm_sound_map u_sound_map (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .rd    (rd)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {(RSP_W - RES_W)'(0), rsp_data_ff};

   `SCM_ASSERT(a_free_mirrors_map, clock, reset, free_ff == ~c2s_vld_ff)
   `SCM_ASSERT(a_scan_bound, clock, reset, (state_ff == ST_SCAN) |-> (cnt_ff <= CNT_W'(NUM_SOUNDS)))
   `SCM_ASSERT(a_rsp_from_out, clock, reset, $rose(rsp_tvalid) |-> ($past(state_ff) == ST_OUT))
   `SCM_ASSERT(a_busy_after_beat, clock, reset, accept |=> !req_tready)
   `SCM_ASSERT_ALWAYS(a_reset_state, clock, reset |=> ((free_ff == '1) && (c2s_vld_ff == '0)))

endmodule
